// ===== sv/utm_pkg.sv =====
// ----------------------------------------------------------------------------
// utm_pkg
// Shared types and constants of the upstream track multiplicity trigger.
// ----------------------------------------------------------------------------
package utm_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COUNT_WIDTH = 8;
  localparam int ZTH_WIDTH   = 15;
  localparam int LZ_WIDTH    = 13;   // holds 1 .. 6400
  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;

  // register indexes (paddr[2])
  localparam logic REG_Z_THRESHOLD = 1'b0;
  localparam logic REG_MAX_UPSTREAM = 1'b1;

  localparam logic [ZTH_WIDTH-1:0]   Z_THRESHOLD_RST = ZTH_WIDTH'(896);
  localparam logic [COUNT_WIDTH-1:0] MAX_UPSTREAM_RST = COUNT_WIDTH'(4);

  // fiducial box, 1/64 cm
  localparam logic [LZ_WIDTH-1:0]           Z_START   = LZ_WIDTH'(6400);
  localparam logic signed [COORD_WIDTH-1:0] BOX_X_HI  = COORD_WIDTH'(2720);
  localparam logic signed [COORD_WIDTH-1:0] BOX_Y_HI  = COORD_WIDTH'(1280);
  localparam logic signed [COORD_WIDTH-1:0] BOX_Y_LO  = -COORD_WIDTH'(1280);
  localparam logic signed [COORD_WIDTH-1:0] BOX_Z_HI  = COORD_WIDTH'(5760);
  localparam logic signed [COORD_WIDTH-1:0] COORD_ZERO = '0;
  localparam logic [COUNT_WIDTH-1:0]        COUNT_MAX = '1;

  typedef struct packed {
    logic [ZTH_WIDTH-1:0]   z_threshold;
    logic [COUNT_WIDTH-1:0] max_upstream_tracks;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_pos;
    logic signed [COORD_WIDTH-1:0] y_pos;
    logic signed [COORD_WIDTH-1:0] z_pos;
    logic                          point_valid;
    logic                          track_end;
    logic                          event_end;
  } item_t;

  typedef struct packed {
    logic                   event_pass;
    logic [COUNT_WIDTH-1:0] upstream_count;
    logic [COUNT_WIDTH-1:0] volume_count;
    logic [COUNT_WIDTH-1:0] total_count;
  } verdict_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + COUNT_WIDTH'(1);
  endfunction

endpackage

// ===== sv/utm_regs.sv =====
// ----------------------------------------------------------------------------
// utm_regs
// APB configuration registers: z threshold and upstream track limit.
// ----------------------------------------------------------------------------
module utm_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [utm_pkg::PADDR_WIDTH-1:0]    paddr,
  input  logic [utm_pkg::PDATA_WIDTH-1:0]    pwdata,
  output logic [utm_pkg::PDATA_WIDTH-1:0]    prdata,
  output logic                               pready,
  output utm_pkg::cfg_t                      cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.z_threshold         <= utm_pkg::Z_THRESHOLD_RST;
      cfg.max_upstream_tracks <= utm_pkg::MAX_UPSTREAM_RST;
    end else if (wr_en) begin
      case (reg_sel)
        utm_pkg::REG_Z_THRESHOLD: begin
          cfg.z_threshold <= pwdata[utm_pkg::ZTH_WIDTH-1:0];
        end
        utm_pkg::REG_MAX_UPSTREAM: begin
          cfg.max_upstream_tracks <= pwdata[utm_pkg::COUNT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      utm_pkg::REG_Z_THRESHOLD:
        prdata = utm_pkg::PDATA_WIDTH'(cfg.z_threshold);
      utm_pkg::REG_MAX_UPSTREAM:
        prdata = utm_pkg::PDATA_WIDTH'(cfg.max_upstream_tracks);
      default:
        prdata = '0;
    endcase
  end

endmodule

// ===== sv/utm_track.sv =====
// ----------------------------------------------------------------------------
// utm_track
// Per-track lowest-z search in the fiducial box and per-event track tallies.
// ----------------------------------------------------------------------------
module utm_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,      // process item this cycle
  input  utm_pkg::item_t    item,
  input  utm_pkg::cfg_t     cfg,
  output utm_pkg::verdict_t verdict    // valid with step when item.event_end
);

  logic [utm_pkg::LZ_WIDTH-1:0]    lowest_z, lowest_z_next;
  logic                            track_is_upstream, track_is_upstream_next;
  logic                            track_in_volume, track_in_volume_next;
  logic [utm_pkg::COUNT_WIDTH-1:0] upstream_tally, upstream_tally_next;
  logic [utm_pkg::COUNT_WIDTH-1:0] volume_tally, volume_tally_next;
  logic [utm_pkg::COUNT_WIDTH-1:0] track_tally, track_tally_next;

  logic                            in_box;
  logic                            take;
  logic [utm_pkg::LZ_WIDTH-1:0]    lz_pt;
  logic                            up_pt;
  logic                            vol_pt;

  // in-box z is in 1..5759, so its low bits compare directly with lowest_z
  assign in_box = (item.z_pos > utm_pkg::COORD_ZERO) && (item.z_pos < utm_pkg::BOX_Z_HI) &&
                  (item.x_pos > utm_pkg::COORD_ZERO) && (item.x_pos < utm_pkg::BOX_X_HI) &&
                  (item.y_pos > utm_pkg::BOX_Y_LO)   && (item.y_pos < utm_pkg::BOX_Y_HI);
  assign take   = item.point_valid && !track_is_upstream && in_box &&
                  (item.z_pos[utm_pkg::LZ_WIDTH-1:0] < lowest_z);

  always_comb begin
    lz_pt  = take ? item.z_pos[utm_pkg::LZ_WIDTH-1:0] : lowest_z;
    vol_pt = track_in_volume || take;
    up_pt  = track_is_upstream ||
             (item.point_valid &&
              (utm_pkg::ZTH_WIDTH'(lz_pt) < cfg.z_threshold));

    lowest_z_next          = lz_pt;
    track_is_upstream_next = up_pt;
    track_in_volume_next   = vol_pt;
    upstream_tally_next    = upstream_tally;
    volume_tally_next      = volume_tally;
    track_tally_next       = track_tally;

    if (item.track_end) begin
      track_tally_next = utm_pkg::sat_inc(track_tally);
      if (up_pt) begin
        upstream_tally_next = utm_pkg::sat_inc(upstream_tally);
      end
      if (vol_pt) begin
        volume_tally_next = utm_pkg::sat_inc(volume_tally);
      end
    end

    verdict.event_pass     = !(upstream_tally_next > cfg.max_upstream_tracks);
    verdict.upstream_count = upstream_tally_next;
    verdict.volume_count   = volume_tally_next;
    verdict.total_count    = track_tally_next;

    // track end or event end drops the open track; event end also restarts the tallies
    if (item.track_end || item.event_end) begin
      lowest_z_next          = utm_pkg::Z_START;
      track_is_upstream_next = 1'b0;
      track_in_volume_next   = 1'b0;
    end
    if (item.event_end) begin
      upstream_tally_next = '0;
      volume_tally_next   = '0;
      track_tally_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_z          <= utm_pkg::Z_START;
      track_is_upstream <= 1'b0;
      track_in_volume   <= 1'b0;
      upstream_tally    <= '0;
      volume_tally      <= '0;
      track_tally       <= '0;
    end else if (step) begin
      lowest_z          <= lowest_z_next;
      track_is_upstream <= track_is_upstream_next;
      track_in_volume   <= track_in_volume_next;
      upstream_tally    <= upstream_tally_next;
      volume_tally      <= volume_tally_next;
      track_tally       <= track_tally_next;
    end
  end

endmodule

// ===== sv/upstream_track_multiplicity_trigger_core.sv =====
// Path from item accept to result valid: input register, then result register.
// Throughput: one item per cycle; the single track/tally update stage sets the rate.
// in_ready drops only while an event-end item waits on a full, stalled result register.
// Reset (rst, synchronous, active high): tallies and track state cleared, lowest z at
// 100 cm, z_threshold = 896, max_upstream_tracks = 4, no item or result held.
// ----------------------------------------------------------------------------
// upstream_track_multiplicity_trigger_core
// Space point stream in, one verdict with track counts out per event.
// ----------------------------------------------------------------------------
module upstream_track_multiplicity_trigger_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // point stream
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [utm_pkg::COORD_WIDTH-1:0] x_pos,
  input  logic signed [utm_pkg::COORD_WIDTH-1:0] y_pos,
  input  logic signed [utm_pkg::COORD_WIDTH-1:0] z_pos,
  input  logic                                  point_valid,
  input  logic                                  track_end,
  input  logic                                  event_end,
  // verdict stream
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  event_pass,
  output logic [utm_pkg::COUNT_WIDTH-1:0]       upstream_count,
  output logic [utm_pkg::COUNT_WIDTH-1:0]       volume_count,
  output logic [utm_pkg::COUNT_WIDTH-1:0]       total_count,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [utm_pkg::PADDR_WIDTH-1:0]       paddr,
  input  logic [utm_pkg::PDATA_WIDTH-1:0]       pwdata,
  output logic [utm_pkg::PDATA_WIDTH-1:0]       prdata,
  output logic                                  pready
);

  utm_pkg::cfg_t     cfg;
  utm_pkg::item_t    item;
  utm_pkg::verdict_t verdict;
  utm_pkg::verdict_t res;
  logic              item_valid;
  logic              out_free;
  logic              step;

  utm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !out_valid || out_ready;
  // items without event end never need the result register
  assign step     = item_valid && (!item.event_end || out_free);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.x_pos       <= x_pos;
      item.y_pos       <= y_pos;
      item.z_pos       <= z_pos;
      item.point_valid <= point_valid;
      item.track_end   <= track_end;
      item.event_end   <= event_end;
    end
  end

  utm_track u_track (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (item),
    .cfg     (cfg),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && item.event_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && item.event_end) begin
      res <= verdict;
    end
  end

  assign event_pass     = res.event_pass;
  assign upstream_count = res.upstream_count;
  assign volume_count   = res.volume_count;
  assign total_count    = res.total_count;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the upstream track multiplicity trigger. Space
// point items go in over a valid/ready stream and a local tally model predicts
// each event verdict, which is checked field by field against the output
// stream. Registers are written and read back over APB. The run covers
// directed corner cases, register extremes, count saturation and randomized
// events under several source idle / sink stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [utm_pkg::COUNT_WIDTH-1:0] count_t;

  // fiducial box and track defaults, 1/64 cm
  localparam int FID_X_HI    = 2720;
  localparam int FID_Y_LIM   = 1280;
  localparam int FID_Z_HI    = 5760;
  localparam int Z_INIT      = 6400;
  localparam int ZTH_RESET   = 896;
  localparam int UPMAX_RESET = 4;
  localparam int DRAIN_CYC   = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [utm_pkg::COORD_WIDTH-1:0] x_pos = '0;
  logic signed [utm_pkg::COORD_WIDTH-1:0] y_pos = '0;
  logic signed [utm_pkg::COORD_WIDTH-1:0] z_pos = '0;
  logic                                  point_valid = 1'b0;
  logic                                  track_end = 1'b0;
  logic                                  event_end = 1'b0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic                                  event_pass;
  count_t                                upstream_count;
  count_t                                volume_count;
  count_t                                total_count;
  logic                                  psel = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite = 1'b0;
  logic [utm_pkg::PADDR_WIDTH-1:0]       paddr = '0;
  logic [utm_pkg::PDATA_WIDTH-1:0]       pwdata = '0;
  logic [utm_pkg::PDATA_WIDTH-1:0]       prdata;
  logic                                  pready;

  upstream_track_multiplicity_trigger_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .z_pos          (z_pos),
    .point_valid    (point_valid),
    .track_end      (track_end),
    .event_end      (event_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_pass     (event_pass),
    .upstream_count (upstream_count),
    .volume_count   (volume_count),
    .total_count    (total_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int n_fail        = 0;
  int n_sent        = 0;
  int cycle_cnt     = 0;

  // tally model state and its copy of the registers
  int                           low_z   = Z_INIT;
  bit                           trk_up  = 1'b0;
  bit                           trk_vol = 1'b0;
  count_t                       up_cnt  = '0;
  count_t                       vol_cnt = '0;
  count_t                       trk_cnt = '0;
  logic [utm_pkg::ZTH_WIDTH-1:0] z_limit  = utm_pkg::ZTH_WIDTH'(ZTH_RESET);
  count_t                       up_limit = count_t'(UPMAX_RESET);

  utm_pkg::verdict_t verdict_q[$];

  function automatic count_t bump(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic void drop_track();
    low_z   = Z_INIT;
    trk_up  = 1'b0;
    trk_vol = 1'b0;
  endfunction

  // point first, then track close, then event close
  function automatic void tally_point(input utm_pkg::item_t it);
    utm_pkg::verdict_t v;
    if (it.point_valid && !trk_up) begin
      if (it.z_pos < low_z && it.z_pos > 0 && it.z_pos < FID_Z_HI &&
          it.x_pos > 0 && it.x_pos < FID_X_HI &&
          it.y_pos > -FID_Y_LIM && it.y_pos < FID_Y_LIM) begin
        low_z   = it.z_pos;
        trk_vol = 1'b1;
      end
      if (low_z < int'(z_limit)) trk_up = 1'b1;
    end
    if (it.track_end) begin
      trk_cnt = bump(trk_cnt);
      if (trk_up) up_cnt = bump(up_cnt);
      if (trk_vol) vol_cnt = bump(vol_cnt);
      drop_track();
    end
    if (it.event_end) begin
      v.event_pass     = (up_cnt <= up_limit);
      v.upstream_count = up_cnt;
      v.volume_count   = vol_cnt;
      v.total_count    = trk_cnt;
      verdict_q.push_back(v);
      drop_track();
      up_cnt  = '0;
      vol_cnt = '0;
      trk_cnt = '0;
    end
  endfunction

  // sink side: check each accepted verdict, then pick next ready
  always @(posedge clk) begin : verdict_check
    utm_pkg::verdict_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict with none expected");
          n_fail++;
        end else begin
          want = verdict_q.pop_front();
          if (event_pass !== want.event_pass) begin
            $error("event_pass: expected %0d, got %0d", want.event_pass, event_pass);
            n_fail++;
          end
          if (upstream_count !== want.upstream_count) begin
            $error("upstream_count: expected %0d, got %0d", want.upstream_count,
                   upstream_count);
            n_fail++;
          end
          if (volume_count !== want.volume_count) begin
            $error("volume_count: expected %0d, got %0d", want.volume_count, volume_count);
            n_fail++;
          end
          if (total_count !== want.total_count) begin
            $error("total_count: expected %0d, got %0d", want.total_count, total_count);
            n_fail++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays high across back-to-back items; dropped only while idling
  task automatic send_item(input utm_pkg::item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    x_pos       <= it.x_pos;
    y_pos       <= it.y_pos;
    z_pos       <= it.z_pos;
    point_valid <= it.point_valid;
    track_end   <= it.track_end;
    event_end   <= it.event_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tally_point(it);
    n_sent++;
  endtask

  // drain all verdicts, then cover items still in flight that make none
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic reg_read_check(input logic idx, input logic [31:0] want);
    logic [31:0] mask;
    mask = (idx == utm_pkg::REG_Z_THRESHOLD) ? 32'h7FFF : 32'hFF;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (want & mask)) begin
      $error("prdata[%0d]: expected %0d, got %0d", idx, want & mask, prdata & mask);
      n_fail++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == utm_pkg::REG_Z_THRESHOLD) z_limit = val[utm_pkg::ZTH_WIDTH-1:0];
    else up_limit = val[utm_pkg::COUNT_WIDTH-1:0];
    reg_read_check(idx, val);
  endtask

  function automatic utm_pkg::item_t point_item(input int x, input int y, input int z,
                                                input bit te, input bit ee);
    utm_pkg::item_t p;
    p.x_pos       = utm_pkg::COORD_WIDTH'(x);
    p.y_pos       = utm_pkg::COORD_WIDTH'(y);
    p.z_pos       = utm_pkg::COORD_WIDTH'(z);
    p.point_valid = 1'b1;
    p.track_end   = te;
    p.event_end   = ee;
    return p;
  endfunction

  // marker coords sit deep upstream in the box, so using them would show
  function automatic utm_pkg::item_t mark_item(input bit te, input bit ee);
    utm_pkg::item_t p;
    p = point_item(100, 0, 1, te, ee);
    p.point_valid = 1'b0;
    return p;
  endfunction

  function automatic utm_pkg::item_t rand_point();
    utm_pkg::item_t p;
    p = point_item(0, 0, 0, 1'b0, 1'b0);
    if ($urandom_range(9) == 0) begin
      p.x_pos = utm_pkg::COORD_WIDTH'($urandom);
      p.y_pos = utm_pkg::COORD_WIDTH'($urandom);
      p.z_pos = utm_pkg::COORD_WIDTH'($urandom);
    end else begin
      p.x_pos = utm_pkg::COORD_WIDTH'(-100 + int'($urandom_range(2920)));
      p.y_pos = utm_pkg::COORD_WIDTH'(-1400 + int'($urandom_range(2800)));
      p.z_pos = utm_pkg::COORD_WIDTH'(-100 + int'($urandom_range(6000)));
    end
    return p;
  endfunction

  function automatic utm_pkg::item_t rand_marker();
    utm_pkg::item_t p;
    p = rand_point();
    p.x_pos       = utm_pkg::COORD_WIDTH'($urandom);
    p.y_pos       = utm_pkg::COORD_WIDTH'($urandom);
    p.z_pos       = utm_pkg::COORD_WIDTH'($urandom);
    p.point_valid = 1'b0;
    return p;
  endfunction

  task automatic send_noise();
    utm_pkg::item_t it;
    it = rand_marker();
    it.point_valid = 1'($urandom_range(1));
    it.track_end   = 1'($urandom_range(1));
    it.event_end   = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic send_event();
    int             n_trk;
    int             n_pts;
    bit             closed;
    utm_pkg::item_t it;
    n_trk = $urandom_range(6);
    for (int t = 0; t < n_trk; t++) begin
      n_pts  = $urandom_range(5);
      closed = 1'b0;
      for (int p = 0; p < n_pts; p++) begin
        it = rand_point();
        if (p == n_pts - 1 && $urandom_range(2) == 0) begin
          it.track_end = 1'b1;
          closed       = 1'b1;
        end
        send_item(it);
      end
      // the last track is sometimes left open at event end
      if (!closed && !(t == n_trk - 1 && $urandom_range(7) == 0)) begin
        it = rand_marker();
        it.track_end = 1'b1;
        send_item(it);
      end
    end
    it = $urandom_range(1) ? rand_point() : rand_marker();
    it.track_end = ($urandom_range(3) == 0);
    it.event_end = 1'b1;
    send_item(it);
  endtask

  task automatic test_reset_values();
    reg_read_check(utm_pkg::REG_Z_THRESHOLD, ZTH_RESET);
    reg_read_check(utm_pkg::REG_MAX_UPSTREAM, UPMAX_RESET);
  endtask

  task automatic test_directed_cases();
    src_idle_pct  = 13;
    snk_stall_pct = 13;
    // box corners inside, then just outside on every face
    send_item(point_item(1, -1279, 1, 1'b0, 1'b0));
    send_item(point_item(100, 0, 2, 1'b0, 1'b0));       // after upstream: ignored
    send_item(mark_item(1'b1, 1'b0));
    send_item(point_item(2719, 1279, 5759, 1'b0, 1'b0));
    send_item(point_item(0, 0, 500, 1'b0, 1'b0));
    send_item(point_item(2720, 0, 500, 1'b0, 1'b0));
    send_item(point_item(100, 1280, 500, 1'b0, 1'b0));
    send_item(point_item(100, -1280, 500, 1'b0, 1'b0));
    send_item(point_item(100, 0, 5760, 1'b0, 1'b0));
    send_item(point_item(100, 0, 0, 1'b0, 1'b0));
    send_item(point_item(-32768, -32768, -32768, 1'b0, 1'b0));
    send_item(point_item(32767, 32767, 32767, 1'b1, 1'b0));
    send_item(mark_item(1'b1, 1'b0));                    // empty track
    send_item(point_item(100, 0, 895, 1'b1, 1'b1));
    // threshold is strict; unclosed track dropped at event end
    send_item(point_item(100, 0, 896, 1'b0, 1'b0));
    send_item(point_item(100, 0, 500, 1'b0, 1'b0));
    send_item(mark_item(1'b0, 1'b1));
    send_item(mark_item(1'b0, 1'b1));                    // empty event
    send_item(mark_item(1'b1, 1'b1));
  endtask

  task automatic test_register_extremes();
    settle();
    reg_write(utm_pkg::REG_Z_THRESHOLD, 0);
    reg_write(utm_pkg::REG_MAX_UPSTREAM, 0);
    send_item(point_item(100, 0, 1, 1'b1, 1'b1));
    settle();
    // threshold above the start value: any first point marks upstream
    reg_write(utm_pkg::REG_Z_THRESHOLD, 32767);
    send_item(point_item(-5, 0, 7000, 1'b1, 1'b0));
    send_item(point_item(100, 0, 100, 1'b1, 1'b1));
    settle();
    reg_write(utm_pkg::REG_Z_THRESHOLD, Z_INIT);
    send_item(point_item(3000, 0, 100, 1'b1, 1'b1));
    settle();
    reg_write(utm_pkg::REG_Z_THRESHOLD, Z_INIT + 1);
    send_item(point_item(3000, 0, 100, 1'b1, 1'b1));
  endtask

  task automatic test_saturation();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    settle();
    reg_write(utm_pkg::REG_Z_THRESHOLD, ZTH_RESET);
    reg_write(utm_pkg::REG_MAX_UPSTREAM, 255);
    for (int i = 0; i < 260; i++) send_item(point_item(100, 0, 10, 1'b1, i == 259));
    settle();
    reg_write(utm_pkg::REG_MAX_UPSTREAM, 254);
    for (int i = 0; i < 260; i++) send_item(point_item(100, 0, 10, 1'b1, i == 259));
  endtask

  task automatic test_random_phases();
    int src_mix[4]  = '{0, 70, 0, 13};
    int snk_mix[4]  = '{0, 0, 70, 13};
    int start;
    int zth;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case ($urandom_range(3))
        0:       zth = $urandom_range(1500);
        1:       zth = 6300 + $urandom_range(200);
        2:       zth = $urandom_range(32767);
        default: zth = 400 + $urandom_range(3000);
      endcase
      reg_write(utm_pkg::REG_Z_THRESHOLD, zth);
      reg_write(utm_pkg::REG_MAX_UPSTREAM,
                $urandom_range(3) != 0 ? $urandom_range(4) : $urandom_range(255));
      src_idle_pct  = src_mix[ph];
      snk_stall_pct = snk_mix[ph];
      start = n_sent;
      while (n_sent - start < 300) begin
        if ($urandom_range(15) == 0) send_noise();
        else send_event();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_cases();
    test_register_extremes();
    test_saturation();
    test_random_phases();
    settle();
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
